// ===== src/block_bitmap_next_fit_allocator_defines.svh =====
// assertion macros shared by the allocator rtl
`ifndef BLOCK_BITMAP_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_NEXT_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define BBNF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBNF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bbnf_pkg.sv =====
package bbnf_pkg;

    // bitmap word held by one cell
    localparam int WORD_W = 32;
    localparam int OFF_W  = 5;
    // width of the block index field
    localparam int IDX_W  = 10;

    typedef enum logic [1:0] {
        OP_OCCUPY = 2'd0,
        OP_FREE   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_FIND   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    // request token that walks down the cell chain
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic             occ;
        logic             up_found;
        logic [IDX_W-1:0] up_idx;
        logic             any_found;
        logic [IDX_W-1:0] any_idx;
    } t_tok;

    // finished result
    typedef struct packed {
        logic             occupied;
        logic             found;
        logic [IDX_W-1:0] free_index;
    } t_res;

    // bits of a word that map to existing blocks
    function automatic logic [WORD_W-1:0] valid_mask(input int base, input int num);
        logic [WORD_W-1:0] m;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = ((base + b) < num);
        end
        return m;
    endfunction

    // position of the lowest set bit (isolate, then encode)
    function automatic logic [OFF_W-1:0] low_pos(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] iso;
        logic [OFF_W-1:0]  pos;
        iso = x & (~x + WORD_W'(1));
        pos = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (iso[b]) begin
                pos = pos | OFF_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

// ===== src/bbnf_cell.sv =====
module bbnf_cell #(
    parameter int NUM_BLOCKS = 1024,
    parameter int CELL       = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bbnf_pkg::t_tok i_tok,
    output bbnf_pkg::t_tok o_tok
);

    localparam int BASE = CELL * bbnf_pkg::WORD_W;
    localparam logic [bbnf_pkg::WORD_W-1:0] VMASK = bbnf_pkg::valid_mask(BASE, NUM_BLOCKS);

    logic [bbnf_pkg::WORD_W-1:0] r_word;
    logic [bbnf_pkg::WORD_W-1:0] n_word;
    bbnf_pkg::t_tok              r_tok;
    bbnf_pkg::t_tok              n_tok;

    logic                        w_hit;
    logic [bbnf_pkg::OFF_W-1:0]  w_off;
    int                          w_start_word;
    logic [bbnf_pkg::WORD_W-1:0] w_up_mask;
    logic [bbnf_pkg::WORD_W-1:0] w_free;
    logic [bbnf_pkg::WORD_W-1:0] w_up_free;

    // address decode and search masks for the passing request
    always_comb begin
        w_start_word = int'(i_tok.idx[bbnf_pkg::IDX_W-1:bbnf_pkg::OFF_W]);
        w_off        = i_tok.idx[bbnf_pkg::OFF_W-1:0];
        w_hit        = i_tok.valid && (w_start_word == CELL);
        if (w_start_word < CELL) begin
            w_up_mask = '1;
        end else if (w_start_word == CELL) begin
            w_up_mask = {bbnf_pkg::WORD_W{1'b1}} << w_off;
        end else begin
            w_up_mask = '0;
        end
        w_free    = ~r_word & VMASK;
        w_up_free = w_free & w_up_mask;
    end

    // update own word and token
    always_comb begin
        n_word = r_word;
        n_tok  = i_tok;
        if (i_tok.valid) begin
            case (i_tok.op)
                bbnf_pkg::OP_OCCUPY: begin
                    if (w_hit && VMASK[w_off]) begin
                        n_word[w_off] = 1'b1;
                    end
                end
                bbnf_pkg::OP_FREE: begin
                    if (w_hit && VMASK[w_off]) begin
                        n_word[w_off] = 1'b0;
                    end
                end
                bbnf_pkg::OP_QUERY: begin
                    if (w_hit) begin
                        n_tok.occ = r_word[w_off] & VMASK[w_off];
                    end
                end
                bbnf_pkg::OP_FIND: begin
                    // first free at or above start
                    if (!i_tok.up_found && (|w_up_free)) begin
                        n_tok.up_found = 1'b1;
                        n_tok.up_idx   = bbnf_pkg::IDX_W'(BASE
                                         + int'(bbnf_pkg::low_pos(w_up_free)));
                    end
                    // first free anywhere, used after wrap
                    if (!i_tok.any_found && (|w_free)) begin
                        n_tok.any_found = 1'b1;
                        n_tok.any_idx   = bbnf_pkg::IDX_W'(BASE
                                          + int'(bbnf_pkg::low_pos(w_free)));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // bitmap word and token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_word <= n_word;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== src/block_bitmap_next_fit_allocator.sv =====
// channel  | valid   | ready   | payload
// request  | i_valid | o_ready | i_operation, i_block_index
// result   | o_valid | i_ready | o_occupied, o_found, o_free_index
//
// each request walks a chain of ceil(NUM_BLOCKS/32) cells, one 32-bit bitmap word per cell,
// one cell per cycle; its result loads into the output register once it leaves the last cell.
// one request is in the chain at a time; the next one is taken the cycle after a result loads.
// reset (i_rst_n low, synchronous) clears every bitmap word at once, all blocks free.
// a stalled result sits in the output register; a request may still run, and if its
// result finds the output busy it parks and o_ready stays low until it moves out.
`include "block_bitmap_next_fit_allocator_defines.svh"

module block_bitmap_next_fit_allocator #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_operation,
    input  logic [bbnf_pkg::IDX_W-1:0] i_block_index,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_occupied,
    output logic                       o_found,
    output logic [bbnf_pkg::IDX_W-1:0] o_free_index
);

    localparam int NUM_WORDS = (NUM_BLOCKS + bbnf_pkg::WORD_W - 1) / bbnf_pkg::WORD_W;

    bbnf_pkg::t_state r_state;
    bbnf_pkg::t_state n_state;

    bbnf_pkg::t_tok   w_tok [NUM_WORDS+1];
    bbnf_pkg::t_tok   w_inj;
    logic [NUM_WORDS-1:0] w_chain_valid;
    bbnf_pkg::t_tok   w_last;
    bbnf_pkg::t_res   w_res;

    bbnf_pkg::t_res   r_park;
    bbnf_pkg::t_res   r_out;
    logic             r_out_valid;
    logic             n_out_valid;

    logic             w_accept;
    logic             w_out_free;
    logic             w_load_run;
    logic             w_load_park;
    logic             w_park;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_last     = w_tok[NUM_WORDS];

    // request injection into the first cell
    always_comb begin
        w_inj       = '0;
        w_inj.valid = w_accept;
        w_inj.op    = bbnf_pkg::t_op'(i_operation);
        if ((bbnf_pkg::t_op'(i_operation) == bbnf_pkg::OP_FIND)
            && (int'(i_block_index) >= NUM_BLOCKS)) begin
            w_inj.idx = '0;
        end else begin
            w_inj.idx = i_block_index;
        end
    end

    assign w_tok[0] = w_inj;

    // cell chain
    for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
        bbnf_cell #(
            .NUM_BLOCKS (NUM_BLOCKS),
            .CELL       (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
        assign w_chain_valid[k] = w_tok[k+1].valid;
    end

    // result from the token leaving the last cell
    always_comb begin
        w_res.occupied = w_last.occ;
        w_res.found    = (w_last.op == bbnf_pkg::OP_FIND)
                         && (w_last.up_found || w_last.any_found);
        if (w_last.up_found) begin
            w_res.free_index = w_last.up_idx;
        end else if (w_last.any_found) begin
            w_res.free_index = w_last.any_idx;
        end else begin
            w_res.free_index = '0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bbnf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = bbnf_pkg::S_RUN;
                end
            end
            bbnf_pkg::S_RUN: begin
                if (w_last.valid) begin
                    n_state = w_out_free ? bbnf_pkg::S_IDLE : bbnf_pkg::S_WAIT;
                end
            end
            bbnf_pkg::S_WAIT: begin
                if (w_out_free) begin
                    n_state = bbnf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbnf_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_ready     = 1'b0;
        w_load_run  = 1'b0;
        w_load_park = 1'b0;
        w_park      = 1'b0;
        case (r_state)
            bbnf_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            bbnf_pkg::S_RUN: begin
                w_load_run = w_last.valid && w_out_free;
                w_park     = w_last.valid && !w_out_free;
            end
            bbnf_pkg::S_WAIT: begin
                w_load_park = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_run || w_load_park) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbnf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // parked and output results
    always_ff @(posedge i_clk) begin
        if (w_park) begin
            r_park <= w_res;
        end
        if (w_load_run) begin
            r_out <= w_res;
        end else if (w_load_park) begin
            r_out <= r_park;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_occupied   = r_out.occupied;
    assign o_found      = r_out.found;
    assign o_free_index = r_out.free_index;

    // checks
    `BBNF_ASSERT(a_one_in_chain, 1'b1, $onehot0(w_chain_valid), "more than one request in chain")
    `BBNF_ASSERT(a_idle_empty, r_state == bbnf_pkg::S_IDLE, !(|w_chain_valid), "token while idle")
    `BBNF_ASSERT(a_last_in_run, w_last.valid, r_state == bbnf_pkg::S_RUN, "result outside run")
    `BBNF_ASSERT(a_wait_full, r_state == bbnf_pkg::S_WAIT, r_out_valid, "parked with free output")
    `BBNF_ASSERT_NEXT(a_accept_run, w_accept, r_state == bbnf_pkg::S_RUN, "accept did not start run")

endmodule

// ===== tb/sv/bbnf_checker.sv =====
`timescale 1ns / 100ps

module bbnf_checker #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [1:0]                 i_operation,
    input  logic [bbnf_pkg::IDX_W-1:0] i_block_index,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  logic                       i_occupied,
    input  logic                       i_found,
    input  logic [bbnf_pkg::IDX_W-1:0] i_free_index,
    output int                         o_fail_count,
    output int                         o_pending
);

    // shadow copy of the occupancy map
    logic [NUM_BLOCKS-1:0] shadow_map;
    // answers owed by the block, oldest first
    bbnf_pkg::t_res        owed_answers[$];
    int                    fault_count = 0;

    // apply one request to the shadow map and work out its answer
    function automatic bbnf_pkg::t_res apply_request(input bbnf_pkg::t_op op,
                                                     input logic [bbnf_pkg::IDX_W-1:0] idx);
        bbnf_pkg::t_res ans;
        int             pos;
        ans = '0;
        case (op)
            bbnf_pkg::OP_OCCUPY: begin
                if (idx < NUM_BLOCKS) shadow_map[idx] = 1'b1;
            end
            bbnf_pkg::OP_FREE: begin
                if (idx < NUM_BLOCKS) shadow_map[idx] = 1'b0;
            end
            bbnf_pkg::OP_QUERY: begin
                if (idx < NUM_BLOCKS) ans.occupied = shadow_map[idx];
            end
            default: begin
                // next-fit: upward from the start, wrapping to index 0
                pos = (idx < NUM_BLOCKS) ? int'(idx) : 0;
                for (int k = 0; k < NUM_BLOCKS; k++) begin
                    if (!ans.found && !shadow_map[pos]) begin
                        ans.found      = 1'b1;
                        ans.free_index = bbnf_pkg::IDX_W'(pos);
                    end
                    pos = (pos + 1 >= NUM_BLOCKS) ? 0 : pos + 1;
                end
            end
        endcase
        return ans;
    endfunction

    // watch both channels: predict on request, compare on result
    always @(posedge i_clk) begin : watch
        bbnf_pkg::t_res want;
        bbnf_pkg::t_res got;
        if (!i_rst_n) begin
            shadow_map = '0;
            owed_answers.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                owed_answers.push_back(apply_request(bbnf_pkg::t_op'(i_operation),
                                                     i_block_index));
            end
            if (i_res_valid && i_res_ready) begin
                got.occupied   = i_occupied;
                got.found      = i_found;
                got.free_index = i_free_index;
                if (owed_answers.size() == 0) begin
                    if (fault_count < 10) begin
                        $display("%0t: unexpected result occ=%b found=%b idx=%0d",
                                 $realtime, got.occupied, got.found, got.free_index);
                    end
                    fault_count++;
                end else begin
                    want = owed_answers.pop_front();
                    if (want !== got) begin
                        if (fault_count < 10) begin
                            $display({"%0t: mismatch expected occ=%b found=%b idx=%0d,",
                                      " got occ=%b found=%b idx=%0d"},
                                     $realtime, want.occupied, want.found, want.free_index,
                                     got.occupied, got.found, got.free_index);
                        end
                        fault_count++;
                    end
                end
            end
        end
        o_pending    <= owed_answers.size();
        o_fail_count <= fault_count;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_BLOCKS   = 1024;
    localparam int LIMIT_CYCLES = 800000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AT      = 700;
    localparam int MIXED_COUNT  = 60;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_ready;
    logic [1:0]                 req_op = bbnf_pkg::OP_QUERY;
    logic [bbnf_pkg::IDX_W-1:0] req_idx = '0;
    logic                       res_valid;
    logic                       res_ready = 1'b0;
    logic                       res_occupied;
    logic                       res_found;
    logic [bbnf_pkg::IDX_W-1:0] res_free_index;

    int                         fail_count;
    int                         pending;
    int                         sent_count = 0;
    int                         cycle_count = 0;
    // no idling on either side while set
    bit                         calm = 1'b0;
    logic [bbnf_pkg::IDX_W-1:0] cursor = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    block_bitmap_next_fit_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_operation   (req_op),
        .i_block_index (req_idx),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_occupied    (res_occupied),
        .o_found       (res_found),
        .o_free_index  (res_free_index)
    );

    bbnf_checker #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_operation   (req_op),
        .i_block_index (req_idx),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_occupied    (res_occupied),
        .i_found       (res_found),
        .i_free_index  (res_free_index),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off while requests keep coming
    initial begin : drain_side
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= calm || ($urandom_range(99) >= 37);
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic offer_request(input bbnf_pkg::t_op op,
                                 input logic [bbnf_pkg::IDX_W-1:0] idx);
        while (!calm && $urandom_range(99) < 37) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_idx   <= idx;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        sent_count++;
        cursor = idx;
    endtask

    function automatic bbnf_pkg::t_op pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 25) return bbnf_pkg::OP_OCCUPY;
        if (r < 45) return bbnf_pkg::OP_FREE;
        if (r < 70) return bbnf_pkg::OP_QUERY;
        return bbnf_pkg::OP_FIND;
    endfunction

    // half the indices land near the last one, so requests meet each other
    function automatic logic [bbnf_pkg::IDX_W-1:0] pick_idx();
        if ($urandom_range(1) == 0) begin
            return cursor + bbnf_pkg::IDX_W'($urandom_range(15));
        end
        return bbnf_pkg::IDX_W'($urandom_range(NUM_BLOCKS - 1));
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty map, edges of the index range, wrap-around
        offer_request(bbnf_pkg::OP_FIND, 10'd0);
        offer_request(bbnf_pkg::OP_FIND, 10'd1023);
        offer_request(bbnf_pkg::OP_QUERY, 10'd0);
        offer_request(bbnf_pkg::OP_OCCUPY, 10'd0);
        offer_request(bbnf_pkg::OP_OCCUPY, 10'd1023);
        offer_request(bbnf_pkg::OP_QUERY, 10'd0);
        offer_request(bbnf_pkg::OP_QUERY, 10'd1023);
        offer_request(bbnf_pkg::OP_QUERY, 10'd1);
        offer_request(bbnf_pkg::OP_FIND, 10'd0);
        offer_request(bbnf_pkg::OP_FIND, 10'd1023);
        offer_request(bbnf_pkg::OP_OCCUPY, 10'd1);
        offer_request(bbnf_pkg::OP_FIND, 10'd1023);
        // word boundary
        offer_request(bbnf_pkg::OP_OCCUPY, 10'd31);
        offer_request(bbnf_pkg::OP_OCCUPY, 10'd32);
        offer_request(bbnf_pkg::OP_FIND, 10'd31);
        offer_request(bbnf_pkg::OP_FREE, 10'd0);
        offer_request(bbnf_pkg::OP_FIND, 10'd1023);
        offer_request(bbnf_pkg::OP_FREE, 10'd1023);
        offer_request(bbnf_pkg::OP_QUERY, 10'd1023);
        // freeing a block that is already free
        offer_request(bbnf_pkg::OP_FREE, 10'd700);
        offer_request(bbnf_pkg::OP_QUERY, 10'd700);
        offer_request(bbnf_pkg::OP_OCCUPY, 10'h2AA);
        offer_request(bbnf_pkg::OP_OCCUPY, 10'h155);
        offer_request(bbnf_pkg::OP_QUERY, 10'h2AA);
        offer_request(bbnf_pkg::OP_FIND, 10'h155);

        // fill the whole map in order, with searches and queries mixed in
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            calm = (i >= 300 && i < 500);
            offer_request(bbnf_pkg::OP_OCCUPY, bbnf_pkg::IDX_W'(i));
            if ($urandom_range(31) == 0) begin
                offer_request($urandom_range(1) ? bbnf_pkg::OP_FIND : bbnf_pkg::OP_QUERY,
                              bbnf_pkg::IDX_W'($urandom_range(NUM_BLOCKS - 1)));
            end
        end
        calm = 1'b0;

        // full map: nothing to find
        offer_request(bbnf_pkg::OP_FIND, 10'd0);
        offer_request(bbnf_pkg::OP_FIND, 10'd1023);
        repeat (4) begin
            offer_request(bbnf_pkg::OP_FIND, bbnf_pkg::IDX_W'($urandom_range(NUM_BLOCKS - 1)));
        end
        repeat (2) begin
            offer_request(bbnf_pkg::OP_QUERY, bbnf_pkg::IDX_W'($urandom_range(NUM_BLOCKS - 1)));
        end

        // mixed traffic punching holes into the full map
        repeat (MIXED_COUNT) offer_request(pick_op(), pick_idx());

        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/bbnf_pkg.sv
src/bbnf_cell.sv
src/block_bitmap_next_fit_allocator.sv
tb/sv/bbnf_checker.sv
tb/sv/tb_top.sv
